### hw/rtl/uigfd_pkg.sv
// uigfd_pkg: types and constants shared by the uart idle gap frame detector
// holds the request and response payload structs, function codes and csr indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package uigfd_pkg;

   // function codes carried by a request transfer
   typedef enum logic [1:0] {
      FUNC_RX_BYTE = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_READ    = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   // csr port
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_TICK_LIMIT    = 1'd1;

   // csr reset values
   localparam logic [7:0] FRAME_LENGTH_LIMIT_RESET = 8'd220;
   localparam logic [3:0] IDLE_TICK_LIMIT_RESET    = 4'd1;

   typedef struct packed {
      func_type   func;
      logic [7:0] rx_byte;
      logic [7:0] read_index;
   } req_type;

   typedef struct packed {
      logic       frame_ready;
      logic [7:0] frame_start;
      logic [7:0] frame_length;
      logic [7:0] read_data;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/uart_idle_gap_frame_detector.sv
// uart_idle_gap_frame_detector: receive ring with length and idle-gap frame closing
// depends on uigfd_pkg for payload structs, function codes and csr indexes
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   uigfd_pkg::req_type
// rsp       out        rsp_valid/rsp_stall   uigfd_pkg::rsp_type
// csr       in         csr_write_en          csr_index, csr_wdata
//
// one item per cycle sustained while rsp_stall stays low; a request passes the
// input register, then the result register and the ring read data register
// every item yields exactly one response
// reset is synchronous: pointers, lengths and idle count are cleared and the
// limits return to their reset values; ring contents are not touched
// a stalled response holds the result register; the input register then holds
// and req_stall rises, so nothing is lost or repeated

module uart_idle_gap_frame_detector #(
   parameter int unsigned RING_SIZE = 256
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // request channel
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire uigfd_pkg::req_type                   req_payload,
   // response channel
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output uigfd_pkg::rsp_type                        rsp_payload,
   // csr write port
   input  wire                                       csr_write_en,
   input  wire  [uigfd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire  [uigfd_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   import uigfd_pkg::*;

   // ring position width and a common width for compares against 8-bit limits
   localparam int unsigned PW = $clog2(RING_SIZE);
   localparam int unsigned CW = (PW > 8) ? PW : 8;

   // ---------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   req_type       s1_req_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ready_ff, rsp_ready_in;
   logic [7:0]    rsp_start_ff, rsp_start_in;
   logic [7:0]    rsp_length_ff, rsp_length_in;
   logic [7:0]    rd_data_ff;

   logic [PW-1:0] write_pos_ff, write_pos_in;
   logic [PW-1:0] read_pos_ff, read_pos_in;
   logic [PW-1:0] pending_len_ff, pending_len_in;
   logic [PW-1:0] previous_len_ff, previous_len_in;
   logic [4:0]    idle_count_ff, idle_count_in;

   logic [7:0]    frame_length_limit_ff, frame_length_limit_in;
   logic [3:0]    idle_tick_limit_ff, idle_tick_limit_in;

   logic [7:0]    ring_store_ff [RING_SIZE];

   // ---------------------------------------------------------------------------
   // flow control
   // ---------------------------------------------------------------------------
   logic advance;   // item in the input register moves into the result register
   logic take_req;  // request transfer this cycle

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // ---------------------------------------------------------------------------
   // read index wrapped to the ring
   // ---------------------------------------------------------------------------
   logic [PW-1:0] read_addr;

   generate
      if (RING_SIZE >= 256) begin : g_wide_ring
         assign read_addr = PW'(s1_req_ff.read_index);
      end else begin : g_narrow_ring
         // constant modulo table over all 8-bit indexes
         logic [PW-1:0] idx_wrap [256];
         for (genvar g = 0; g < 256; g++) begin : g_idx
            assign idx_wrap[g] = PW'(g % RING_SIZE);
         end
         assign read_addr = idx_wrap[s1_req_ff.read_index];
      end
   endgenerate

   // ---------------------------------------------------------------------------
   // single-pass step logic
   // ---------------------------------------------------------------------------
   logic [PW:0]   wp_inc;
   logic [PW-1:0] new_pending;
   logic [PW:0]   rp_sum;
   logic [CW-1:0] pending_wide;
   logic [CW-1:0] read_pos_wide;
   logic [CW-1:0] limit_wide;
   logic [4:0]    idle_inc;
   logic          over_limit;
   logic          held_len;
   logic          close;

   // next write position, one bit wider so that the wrap can be detected
   assign wp_inc = {1'b0, write_pos_ff} + (PW+1)'(1);

   // pending length, modulo ring size
   always_comb begin
      if (write_pos_ff >= read_pos_ff) begin
         new_pending = write_pos_ff - read_pos_ff;
      end else begin
         new_pending = PW'((PW+1)'(RING_SIZE) + {1'b0, write_pos_ff}
                           - {1'b0, read_pos_ff});
      end
   end

   assign pending_wide  = CW'(new_pending);
   assign read_pos_wide = CW'(read_pos_ff);
   assign limit_wide    = CW'(frame_length_limit_ff);
   assign over_limit    = pending_wide > limit_wide;
   // same nonzero length seen on two ticks in a row
   assign held_len      = (new_pending != '0) && (new_pending == pending_len_ff);
   assign idle_inc      = idle_count_ff + 5'd1;

   // read position after closing a frame
   assign rp_sum = {1'b0, read_pos_ff} + {1'b0, new_pending};

   always_comb begin
      write_pos_in    = write_pos_ff;
      read_pos_in     = read_pos_ff;
      pending_len_in  = pending_len_ff;
      previous_len_in = previous_len_ff;
      idle_count_in   = idle_count_ff;
      close           = 1'b0;

      if (advance) begin
         case (s1_req_ff.func)
            FUNC_RX_BYTE: begin
               write_pos_in = (wp_inc == (PW+1)'(RING_SIZE)) ? '0 : wp_inc[PW-1:0];
            end
            FUNC_TICK: begin
               previous_len_in = pending_len_ff;
               pending_len_in  = new_pending;
               if (over_limit) begin
                  idle_count_in = '0;
                  close         = 1'b1;
               end else if (held_len) begin
                  if (idle_inc > 5'(idle_tick_limit_ff)) begin
                     idle_count_in = '0;
                     close         = 1'b1;
                  end else begin
                     idle_count_in = idle_inc;
                  end
               end else begin
                  idle_count_in = '0;
               end
               if (close) begin
                  read_pos_in     = (rp_sum >= (PW+1)'(RING_SIZE))
                                    ? PW'(rp_sum - (PW+1)'(RING_SIZE))
                                    : rp_sum[PW-1:0];
                  pending_len_in  = '0;
                  previous_len_in = '0;
               end
            end
            default: begin
               // reads and the unused code leave the framing state alone
            end
         endcase
      end
   end

   // result fields, all zero unless a frame closed
   always_comb begin
      rsp_ready_in  = rsp_ready_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_length_in = rsp_length_ff;
      if (advance) begin
         rsp_ready_in  = close;
         rsp_start_in  = close ? read_pos_wide[7:0] : 8'd0;
         rsp_length_in = close ? pending_wide[7:0] : 8'd0;
      end
   end

   // ---------------------------------------------------------------------------
   // csr writes
   // ---------------------------------------------------------------------------
   always_comb begin
      frame_length_limit_in = frame_length_limit_ff;
      idle_tick_limit_in    = idle_tick_limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_LENGTH_LIMIT: frame_length_limit_in = csr_wdata[7:0];
            CSR_IDLE_TICK_LIMIT:    idle_tick_limit_in    = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // sequential logic
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         write_pos_ff          <= '0;
         read_pos_ff           <= '0;
         pending_len_ff        <= '0;
         previous_len_ff       <= '0;
         idle_count_ff         <= '0;
         frame_length_limit_ff <= FRAME_LENGTH_LIMIT_RESET;
         idle_tick_limit_ff    <= IDLE_TICK_LIMIT_RESET;
      end else begin
         s1_valid_ff           <= s1_valid_in;
         rsp_valid_ff          <= rsp_valid_in;
         write_pos_ff          <= write_pos_in;
         read_pos_ff           <= read_pos_in;
         pending_len_ff        <= pending_len_in;
         previous_len_ff       <= previous_len_in;
         idle_count_ff         <= idle_count_in;
         frame_length_limit_ff <= frame_length_limit_in;
         idle_tick_limit_ff    <= idle_tick_limit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_req_ff <= req_payload;
      end
      rsp_ready_ff  <= rsp_ready_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_length_ff <= rsp_length_in;
   end

   // ring store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (advance && (s1_req_ff.func == FUNC_RX_BYTE)) begin
         ring_store_ff[write_pos_ff] <= s1_req_ff.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (s1_req_ff.func == FUNC_READ) begin
            rd_data_ff <= ring_store_ff[read_addr];
         end else begin
            rd_data_ff <= 8'd0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------------
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.frame_ready  = rsp_ready_ff;
   assign rsp_payload.frame_start  = rsp_start_ff;
   assign rsp_payload.frame_length = rsp_length_ff;
   assign rsp_payload.read_data    = rd_data_ff;

endmodule

`default_nettype wire
